>>> rtl/afk_pkg.sv
// Shared constants, types and the arctangent table of the arm kinematics pipeline.
package afk_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN = 24;
  localparam int CORDIC_CELLS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  localparam int ANG_W = 17;
  localparam int SUM_W = 19;
  localparam int XY_W = 27;
  localparam int Z_W = 25;
  localparam int POS_W = 19;
  localparam int LEN_W = 16;
  localparam int SHIFT_W = 5;

  localparam logic [SUM_W-1:0] FULL_TURN = 19'd46080;
  localparam logic [SUM_W-1:0] QUARTER_TURN = 19'd11520;
  localparam logic [SUM_W-1:0] WRAP_OFFSET = 19'd230400;
  localparam int ANGLE_SHIFT = 9;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 27'sd10188014;
  localparam logic [LEN_W-1:0] LINK_RESET = 16'd4096;
  localparam logic signed [POS_W-1:0] OUT_LIMIT = 19'sd262140;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic [1:0] quad;
  } lane_t;

  function automatic logic signed [Z_W-1:0] atan_q16(input logic [SHIFT_W-1:0] idx);
    logic signed [Z_W-1:0] t;
    unique case (idx)
      5'd0: t = 25'sd2949120;
      5'd1: t = 25'sd1740967;
      5'd2: t = 25'sd919879;
      5'd3: t = 25'sd466945;
      5'd4: t = 25'sd234379;
      5'd5: t = 25'sd117304;
      5'd6: t = 25'sd58666;
      5'd7: t = 25'sd29335;
      5'd8: t = 25'sd14668;
      5'd9: t = 25'sd7334;
      5'd10: t = 25'sd3667;
      5'd11: t = 25'sd1833;
      5'd12: t = 25'sd917;
      5'd13: t = 25'sd458;
      5'd14: t = 25'sd229;
      5'd15: t = 25'sd115;
      5'd16: t = 25'sd57;
      5'd17: t = 25'sd29;
      5'd18: t = 25'sd14;
      5'd19: t = 25'sd7;
      5'd20: t = 25'sd4;
      5'd21: t = 25'sd2;
      5'd22: t = 25'sd1;
      default: t = 25'sd0;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/afk_angle_prep.sv
// Angle wrap to one turn, quadrant split and CORDIC start values for one lane.
module afk_angle_prep
  import afk_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [SUM_W-1:0] ang,
  output lane_t                   lane
);

  logic [SUM_W-1:0] wrapped;
  logic [SUM_W-1:0] turn;
  logic [1:0] quad_next;
  logic [SUM_W-1:0] res;

  always_comb begin
    wrapped = SUM_W'(ang) + WRAP_OFFSET;
    if (wrapped >= SUM_W'(FULL_TURN * 8)) wrapped = wrapped - SUM_W'(FULL_TURN * 8);
    if (wrapped >= SUM_W'(FULL_TURN * 4)) wrapped = wrapped - SUM_W'(FULL_TURN * 4);
    if (wrapped >= SUM_W'(FULL_TURN * 2)) wrapped = wrapped - SUM_W'(FULL_TURN * 2);
    if (wrapped >= FULL_TURN) wrapped = wrapped - FULL_TURN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      turn <= wrapped;
    end
  end

  always_comb begin
    priority if (turn >= SUM_W'(QUARTER_TURN * 3)) begin
      quad_next = QUAD_3;
      res = turn - SUM_W'(QUARTER_TURN * 3);
    end else if (turn >= SUM_W'(QUARTER_TURN * 2)) begin
      quad_next = QUAD_2;
      res = turn - SUM_W'(QUARTER_TURN * 2);
    end else if (turn >= QUARTER_TURN) begin
      quad_next = QUAD_1;
      res = turn - QUARTER_TURN;
    end else begin
      quad_next = QUAD_0;
      res = turn;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane.x <= CORDIC_GAIN;
      lane.y <= '0;
      lane.z <= $signed(Z_W'({res, ANGLE_SHIFT'(0)}));
      lane.quad <= quad_next;
    end
  end

endmodule

>>> rtl/afk_cordic_cell.sv
// One rotation step of the CORDIC chain for one lane.
module afk_cordic_cell
  import afk_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [SHIFT_W-1:0] shift,
  input  lane_t              din,
  output lane_t              dout
);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0] step;

  always_comb begin
    dx = din.y >>> shift;
    dy = din.x >>> shift;
    step = atan_q16(shift);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!din.z[Z_W-1]) begin
        dout.x <= din.x - dx;
        dout.y <= din.y + dy;
        dout.z <= din.z - step;
      end else begin
        dout.x <= din.x + dx;
        dout.y <= din.y - dy;
        dout.z <= din.z + step;
      end
      dout.quad <= din.quad;
    end
  end

endmodule

>>> rtl/afk_position.sv
// Quadrant fix-up, angle sums, link scaling, rounding and saturation of the position.
module afk_position
  import afk_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [LEN_W-1:0]        link_length,
  input  lane_t                   yaw,
  input  lane_t                   pa,
  input  lane_t                   pab,
  input  lane_t                   pabc,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z
);

  localparam int S_W = XY_W + 2;
  localparam int P_W = S_W + LEN_W + 1;
  localparam int R_W = 32;
  localparam int M_W = R_W + XY_W;
  localparam int Q_W = 22;

  function automatic logic signed [XY_W-1:0] fix_cos(input lane_t l);
    logic signed [XY_W-1:0] v;
    unique case (l.quad)
      QUAD_0: v = l.x;
      QUAD_1: v = -l.y;
      QUAD_2: v = -l.x;
      default: v = l.y;
    endcase
    return v;
  endfunction

  function automatic logic signed [XY_W-1:0] fix_sin(input lane_t l);
    logic signed [XY_W-1:0] v;
    unique case (l.quad)
      QUAD_0: v = l.y;
      QUAD_1: v = l.x;
      QUAD_2: v = -l.y;
      default: v = -l.x;
    endcase
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] sat(input logic signed [Q_W:0] v);
    logic signed [POS_W-1:0] r;
    priority if (v > Q_W'(OUT_LIMIT)) r = OUT_LIMIT;
    else if (v < -Q_W'(OUT_LIMIT)) r = -OUT_LIMIT;
    else r = v[POS_W-1:0];
    return r;
  endfunction

  logic signed [XY_W-1:0] c1_1, s1_1, c1_2, s1_2, c1_3, s1_3;
  logic signed [S_W-1:0] sum_c, sum_s;
  logic signed [P_W-1:0] prod_c, prod_s;
  logic signed [P_W-1:0] rnd_c, rnd_s;
  logic signed [R_W-1:0] rq;
  logic signed [Q_W:0] pz_3, pz_4;
  logic signed [M_W-1:0] prod_x, prod_y;
  logic signed [M_W-1:0] rnd_x, rnd_y;
  logic signed [LEN_W:0] len_s;

  always_comb begin
    len_s = $signed({1'b0, link_length});
    rnd_c = prod_c + P_W'(1 << 11);
    rnd_s = P_W'(1 << 23) - prod_s;
    rnd_x = prod_x + (M_W'(1) <<< 35);
    rnd_y = prod_y + (M_W'(1) <<< 35);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_1 <= fix_cos(yaw);
      s1_1 <= fix_sin(yaw);
      sum_c <= S_W'(fix_cos(pa)) + S_W'(fix_cos(pab)) + (S_W'(fix_cos(pabc)) <<< 1);
      sum_s <= S_W'(fix_sin(pa)) + S_W'(fix_sin(pab)) + (S_W'(fix_sin(pabc)) <<< 1);
      c1_2 <= c1_1;
      s1_2 <= s1_1;
      prod_c <= P_W'(sum_c * len_s);
      prod_s <= P_W'(sum_s * len_s);
      c1_3 <= c1_2;
      s1_3 <= s1_2;
      rq <= rnd_c[R_W+11:12];
      pz_3 <= (Q_W+1)'(rnd_s >>> 24);
      prod_x <= M_W'(rq * c1_3);
      prod_y <= M_W'(rq * s1_3);
      pz_4 <= pz_3;
      pos_x <= sat(rnd_x[Q_W+36:36]);
      pos_y <= sat(rnd_y[Q_W+36:36]);
      pos_z <= sat(pz_4);
    end
  end

endmodule

>>> rtl/arm_forward_kinematics.sv
// Top level of the four-joint arm forward kinematics pipeline.
// A request passes the angle-prep registers, the CORDIC cells and the position stages to the result.
// Throughput: one request per cycle; the whole pipeline advances unless the output is stalled.
// The output register holds a result while the consumer is not ready.
// Reset clears the valid pipeline and sets link_length to 4096.
module arm_forward_kinematics
  import afk_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  // base_yaw_angle, shoulder_pitch_angle, elbow_pitch_angle, wrist_pitch_angle, zero pad
  input  logic [71:0]      s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // pos_x, pos_y, pos_z, zero pad
  output logic [63:0]      m_tdata
);

  localparam int LAT = CORDIC_CELLS + 7;

  logic [LEN_W-1:0] link_length;
  logic [LAT-1:0] valid_pipe;
  logic en;
  logic signed [ANG_W-1:0] j1, j2, j3, j4;
  logic signed [SUM_W-1:0] ang [4];
  lane_t chain [CORDIC_CELLS+1][4];
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = valid_pipe[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      link_length <= LINK_RESET;
    end else if (cfg_wr_en) begin
      link_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (en) begin
      valid_pipe <= {valid_pipe[LAT-2:0], s_tvalid};
    end
  end

  always_comb begin
    j1 = $signed(s_tdata[16:0]);
    j2 = $signed(s_tdata[33:17]);
    j3 = $signed(s_tdata[50:34]);
    j4 = $signed(s_tdata[67:51]);
    ang[0] = SUM_W'(j1);
    ang[1] = SUM_W'(j2);
    ang[2] = SUM_W'(j2) + SUM_W'(j3);
    ang[3] = SUM_W'(j2) + SUM_W'(j3) + SUM_W'(j4);
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    afk_angle_prep u_prep (
      .clk  (clk),
      .en   (en),
      .ang  (ang[l]),
      .lane (chain[0][l])
    );
    for (genvar c = 0; c < CORDIC_CELLS; c++) begin : g_cell
      afk_cordic_cell u_cell (
        .clk   (clk),
        .en    (en),
        .shift (SHIFT_W'(c)),
        .din   (chain[c][l]),
        .dout  (chain[c+1][l])
      );
    end
  end

  afk_position u_pos (
    .clk         (clk),
    .en          (en),
    .link_length (link_length),
    .yaw         (chain[CORDIC_CELLS][0]),
    .pa          (chain[CORDIC_CELLS][1]),
    .pab         (chain[CORDIC_CELLS][2]),
    .pabc        (chain[CORDIC_CELLS][3]),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z)
  );

  assign m_tdata = {7'd0, pos_z, pos_y, pos_x};

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pos_x <= OUT_LIMIT && pos_x >= -OUT_LIMIT))
    else $error("pos_x beyond limit");
  a_y_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pos_y <= OUT_LIMIT && pos_y >= -OUT_LIMIT))
    else $error("pos_y beyond limit");
  a_z_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pos_z <= OUT_LIMIT && pos_z >= -OUT_LIMIT))
    else $error("pos_z beyond limit");

endmodule

>>> tb/tb_arm_forward_kinematics.sv
// Self-checking testbench of the arm forward kinematics pipeline with a built-in position predictor.
`timescale 1ns / 100ps

module tb_arm_forward_kinematics;
  import afk_pkg::*;

  typedef struct {
    logic signed [ANG_W-1:0] yaw;
    logic signed [ANG_W-1:0] shoulder;
    logic signed [ANG_W-1:0] elbow;
    logic signed [ANG_W-1:0] wrist;
    bit is_cfg;
    bit drain;
    logic [LEN_W-1:0] len_val;
  } pose_t;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } position_t;

  localparam longint ATAN_TAB [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
  localparam int RUN_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;

  pose_t pose_queue[$];
  position_t position_queue[$];
  logic [LEN_W-1:0] link_len = LINK_RESET;
  int errors = 0;
  int cycles = 0;
  bit stimulus_done = 1'b0;
  int gap_left = 0;
  int burst_left = 0;
  int quiet_left = 0;
  bit busy = 1'b0;

  arm_forward_kinematics dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

  always #10 clk = ~clk;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  task automatic trig(input longint ang, output longint c, output longint s);
    longint m, res, x, y, z, dx, dy;
    int q;
    m = ang % 46080;
    if (m < 0) m += 46080;
    q = int'(m / 11520);
    res = m - longint'(q) * 11520;
    x = 10188014;
    y = 0;
    z = res <<< ANGLE_SHIFT;
    for (int i = 0; i < CORDIC_CELLS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    case (q)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic logic signed [POS_W-1:0] clamp(longint v);
    if (v > 262140) v = 262140;
    if (v < -262140) v = -262140;
    return v[POS_W-1:0];
  endfunction

  task automatic predict_position(input pose_t p);
    longint c1, s1, ca, sa, cab, sab, cabc, sabc, sc, ss, len, rq;
    position_t r;
    trig(p.yaw, c1, s1);
    trig(p.shoulder, ca, sa);
    trig(longint'(p.shoulder) + p.elbow, cab, sab);
    trig(longint'(p.shoulder) + p.elbow + p.wrist, cabc, sabc);
    sc = ca + cab + 2 * cabc;
    ss = sa + sab + 2 * sabc;
    len = link_len;
    rq = round_shift(len * sc, 12);
    r.x = clamp(round_shift(rq * c1, 36));
    r.y = clamp(round_shift(rq * s1, 36));
    r.z = clamp(round_shift(-(len * ss), 24));
    position_queue.push_back(r);
  endtask

  function automatic logic signed [ANG_W-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 17'sh0FFFF : 17'sh10000;
      1: return 17'(int'($urandom_range(0, 92160)) - 46080);
      default: return 17'(int'($urandom_range(0, 11520)) - 5760);
    endcase
  endfunction

  function automatic pose_t make_pose(int a, int b, int c, int d);
    pose_t p;
    p = '{default: '0};
    p.yaw = a[ANG_W-1:0];
    p.shoulder = b[ANG_W-1:0];
    p.elbow = c[ANG_W-1:0];
    p.wrist = d[ANG_W-1:0];
    return p;
  endfunction

  task automatic add_length(input logic [LEN_W-1:0] v);
    pose_t p;
    p = '{default: '0};
    p.is_cfg = 1'b1;
    p.len_val = v;
    pose_queue.push_back(p);
  endtask

  task automatic add_drain();
    pose_t p;
    p = '{default: '0};
    p.drain = 1'b1;
    pose_queue.push_back(p);
  endtask

  initial begin
    pose_t p;
    int specials [0:7] = '{0, 11520, 23040, 34560, 46080, -46080, 65535, -65536};
    foreach (specials[k]) pose_queue.push_back(make_pose(specials[k], specials[7 - k], 0, 0));
    pose_queue.push_back(make_pose(5760, 2000, -3000, 46079));
    pose_queue.push_back(make_pose(-1, 40000, 40000, 40000));
    pose_queue.push_back(make_pose(0, -65536, -65536, -65536));
    pose_queue.push_back(make_pose(65535, 65535, 65535, 65535));
    add_length(16'hFFFF);
    pose_queue.push_back(make_pose(0, 0, 0, 0));
    pose_queue.push_back(make_pose(5760, 0, 0, 0));
    pose_queue.push_back(make_pose(0, 11520, 0, 0));
    pose_queue.push_back(make_pose(0, -11520, 0, 0));
    add_length(16'h0000);
    pose_queue.push_back(make_pose(1234, 4321, -999, 777));
    add_drain();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: add_length(16'd4096);
        1: add_length(16'd1);
        2: add_length(16'hFFFF);
        3: add_length(16'($urandom_range(0, 65535)));
        default: add_length(16'($urandom_range(20000, 40000)));
      endcase
      for (int n = 0; n < 90; n++) begin
        p = '{default: '0};
        p.yaw = rand_angle();
        p.shoulder = rand_angle();
        p.elbow = rand_angle();
        p.wrist = rand_angle();
        pose_queue.push_back(p);
      end
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    bit cfg_fire;
    cfg_fire = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_position(pose_queue.pop_front());
        busy = 1'b0;
      end
      if (busy) begin
      end else if (pose_queue.size() == 0) begin
        s_tvalid <= 1'b0;
        stimulus_done = 1'b1;
      end else if (pose_queue[0].is_cfg || pose_queue[0].drain) begin
        s_tvalid <= 1'b0;
        if (position_queue.size() == 0 && !m_tvalid) begin
          if (quiet_left < 40) quiet_left++;
          else begin
            quiet_left = 0;
            if (pose_queue[0].is_cfg) begin
              cfg_fire = 1'b1;
              cfg_wr_data <= pose_queue[0].len_val;
              link_len = pose_queue[0].len_val;
            end
            void'(pose_queue.pop_front());
          end
        end else quiet_left = 0;
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata <= {4'h0, pose_queue[0].wrist, pose_queue[0].elbow,
                    pose_queue[0].shoulder, pose_queue[0].yaw};
        busy = 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      cfg_wr_en <= cfg_fire;
    end
  end

  always @(posedge clk) begin
    position_t e;
    logic signed [POS_W-1:0] gx, gy, gz;
    cycles++;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        gx = m_tdata[18:0];
        gy = m_tdata[37:19];
        gz = m_tdata[56:38];
        if (position_queue.size() == 0) begin
          $error("result with no pose pending");
          errors++;
        end else begin
          e = position_queue.pop_front();
          if (gx !== e.x) begin
            $error("pos_x expected %0d got %0d", e.x, gx); errors++;
          end
          if (gy !== e.y) begin
            $error("pos_y expected %0d got %0d", e.y, gy); errors++;
          end
          if (gz !== e.z) begin
            $error("pos_z expected %0d got %0d", e.z, gz); errors++;
          end
        end
      end
      m_tready <= ((cycles % 97) < 30) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    wait (!rst);
    while (!(stimulus_done && position_queue.size() == 0) && cycles < RUN_LIMIT)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (cycles >= RUN_LIMIT) begin
      $display("FAILED: results differ");
    end else if (errors == 0 && position_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
